@@ hw/rtl/espar_pkg.sv @@
package espar_pkg;

   // Default sizes handed to the top level parameters
   localparam int unsigned DEF_NUM_SA      = 16;
   localparam int unsigned DEF_WINDOW_BITS = 32;

   // Fixed field widths
   localparam int unsigned SA_INDEX_W  = 4;
   localparam int unsigned SEQ_W       = 32;
   localparam int unsigned WIN_SIZE_W  = 6;
   localparam int unsigned VERDICT_W   = 3;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_COUNTER = 1'd1;

   // Register reset values
   localparam logic [WIN_SIZE_W-1:0] WINDOW_SIZE_RST   = 6'd32;
   localparam logic [SEQ_W-1:0]      START_COUNTER_RST = 32'd1;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_NEWER = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_OOO   = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_ROLL  = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_ZERO  = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_OLD   = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_DUP   = 3'd5;

   typedef struct packed {
      logic [SA_INDEX_W-1:0] sa_index;
      logic [SEQ_W-1:0]      seq_number;
   } req_payload_type;

   typedef struct packed {
      logic                 accept;
      logic [VERDICT_W-1:0] verdict;
   } rsp_payload_type;

endpackage

@@ hw/rtl/espar_ram.sv @@
module espar_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/espar_check.sv @@
module espar_check #(
   parameter int unsigned WINDOW_BITS = espar_pkg::DEF_WINDOW_BITS
) (
   input  logic [espar_pkg::SEQ_W-1:0]      seq_number,
   input  logic [espar_pkg::SEQ_W-1:0]      last_seq,
   input  logic [WINDOW_BITS-1:0]           seen_map,
   input  logic [espar_pkg::SEQ_W-1:0]      start_counter,
   input  logic [espar_pkg::WIN_SIZE_W-1:0] window_size,
   output espar_pkg::rsp_payload_type       result,
   output logic [espar_pkg::SEQ_W-1:0]      last_seq_nxt,
   output logic [WINDOW_BITS-1:0]           seen_map_nxt
);

   // Shift amounts stay below the window, which is at most WINDOW_BITS
   localparam int unsigned ShW = $clog2(WINDOW_BITS + 1);
   localparam logic [WINDOW_BITS-1:0] MapOne = WINDOW_BITS'(1);

   logic [espar_pkg::SEQ_W-1:0] win;
   logic [espar_pkg::SEQ_W-1:0] up_gap;
   logic [espar_pkg::SEQ_W-1:0] dn_gap;
   logic                        borrow;
   logic                        newer;
   logic [WINDOW_BITS-1:0]      seen_shr;

   // Window saturates at the bitmap width
   always_comb begin
      if (32'(window_size) > 32'(WINDOW_BITS)) begin
         win = espar_pkg::SEQ_W'(WINDOW_BITS);
      end else begin
         win = espar_pkg::SEQ_W'(window_size);
      end
   end

   // Distance to the highest accepted number, both directions
   assign {borrow, up_gap} = {1'b0, seq_number} - {1'b0, last_seq};
   assign newer            = !borrow && (up_gap != '0);
   assign dn_gap           = last_seq - seq_number;
   assign seen_shr         = seen_map >> dn_gap[ShW-1:0];

   // Decision order: zero, rollover, newer, older
   always_comb begin
      last_seq_nxt   = last_seq;
      seen_map_nxt   = seen_map;
      result.accept  = 1'b0;
      result.verdict = espar_pkg::VERDICT_ZERO;
      if (seq_number == '0) begin
         result.verdict = espar_pkg::VERDICT_ZERO;
      end else if (seq_number == start_counter && last_seq != start_counter) begin
         seen_map_nxt   = '0;
         last_seq_nxt   = seq_number;
         result.accept  = 1'b1;
         result.verdict = espar_pkg::VERDICT_ROLL;
      end else if (newer) begin
         if (up_gap < win) begin
            seen_map_nxt = (seen_map << up_gap[ShW-1:0]) | MapOne;
         end else begin
            seen_map_nxt = MapOne;
         end
         last_seq_nxt   = seq_number;
         result.accept  = 1'b1;
         result.verdict = espar_pkg::VERDICT_NEWER;
      end else if (dn_gap >= win) begin
         result.verdict = espar_pkg::VERDICT_OLD;
      end else if (seen_shr[0]) begin
         result.verdict = espar_pkg::VERDICT_DUP;
      end else begin
         seen_map_nxt   = seen_map | (MapOne << dn_gap[ShW-1:0]);
         result.accept  = 1'b1;
         result.verdict = espar_pkg::VERDICT_OOO;
      end
   end

endmodule

@@ hw/rtl/esp_anti_replay_window.sv @@
// ESP anti-replay window check, one verdict per request.
// Request channel (req_*): security association index and sequence number.
// Response channel (rsp_*): accept flag and verdict code. Both channels use
// valid/stall; a transfer happens on a clock edge with valid high, stall low.
// CSR port: csr_wr_en writes window_size (index 0) or start_counter
// (index 1) at the clock edge; the user must write only while no request is
// in flight, as the block itself does not enforce it. A request taken passes
// the check stage, then the response register; a receiver stall holds it.
// Throughput: one request per cycle while req_stall is low; per-association
// state sits in a RAM with a registered read, and the last write is forwarded
// so back-to-back requests to the same association see up-to-date state.
// Reset: synchronous, active high. Control and configuration registers go to
// their reset values, then a clearing pass writes zero to every association
// in turn, with req_stall held high. CSR writes are taken during the pass.
// Receiver stall: the response register holds; one more request may sit in
// the check stage, after which req_stall rises until rsp_stall drops.
module esp_anti_replay_window #(
   parameter int unsigned NUM_SA      = espar_pkg::DEF_NUM_SA,
   parameter int unsigned WINDOW_BITS = espar_pkg::DEF_WINDOW_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  espar_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output espar_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [espar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [espar_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SaW    = (NUM_SA > 1) ? $clog2(NUM_SA) : 1;
   localparam int unsigned StateW = espar_pkg::SEQ_W + WINDOW_BITS;
   localparam int unsigned NumIdx = 2 ** espar_pkg::SA_INDEX_W;
   localparam logic [SaW-1:0] LastSa = SaW'(NUM_SA - 1);

   // Configuration registers
   logic [espar_pkg::WIN_SIZE_W-1:0] window_size_ff;
   logic [espar_pkg::SEQ_W-1:0]      start_counter_ff;

   // Clearing pass
   logic           clear_ff, clear_in;
   logic [SaW-1:0] clr_addr_ff, clr_addr_in;

   // Check stage
   logic                        s1_valid_ff, s1_valid_in;
   logic [SaW-1:0]              s1_addr_ff;
   logic [espar_pkg::SEQ_W-1:0] s1_seq_ff;
   logic                        s1_go;
   logic                        s1_hold;
   logic                        commit;

   // Last RAM write, forwarded to the check stage
   logic              wr_valid_ff, wr_valid_in;
   logic [SaW-1:0]    wr_addr_ff;
   logic [StateW-1:0] wr_data_ff;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   espar_pkg::rsp_payload_type rsp_payload_ff;

   logic                         req_accept;
   logic [SaW-1:0]               req_addr;
   logic [NumIdx-1:0][SaW-1:0]   sa_tbl;

   logic              ram_wr_en;
   logic [SaW-1:0]    ram_wr_addr;
   logic [StateW-1:0] ram_wr_data;
   logic [SaW-1:0]    ram_rd_addr;
   logic [StateW-1:0] ram_rd_data;

   logic [StateW-1:0]             state_cur;
   logic [StateW-1:0]             state_nxt;
   logic [espar_pkg::SEQ_W-1:0]   last_seq_nxt;
   logic [WINDOW_BITS-1:0]        seen_map_nxt;
   espar_pkg::rsp_payload_type    check_result;

   // Association index wraps modulo NUM_SA: constant lookup table
   for (genvar i = 0; i < NumIdx; i++) begin : g_sa_tbl
      localparam int unsigned Wrapped = i % NUM_SA;
      assign sa_tbl[i] = SaW'(Wrapped);
   end
   assign req_addr = sa_tbl[req_payload.sa_index];

   // Handshake
   assign s1_go      = !rsp_valid_ff || !rsp_stall;
   assign s1_hold    = s1_valid_ff && !s1_go;
   assign commit     = s1_valid_ff && s1_go;
   assign req_stall  = clear_ff || s1_hold;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= espar_pkg::WINDOW_SIZE_RST;
         start_counter_ff <= espar_pkg::START_COUNTER_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            espar_pkg::REG_WINDOW_SIZE: begin
               window_size_ff <= csr_wdata[espar_pkg::WIN_SIZE_W-1:0];
            end
            espar_pkg::REG_START_COUNTER: begin
               start_counter_ff <= csr_wdata[espar_pkg::SEQ_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clearing pass sequencing
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + SaW'(1);
         if (clr_addr_ff == LastSa) begin
            clear_in = 1'b0;
         end
      end
   end

   // Pipeline control next values
   assign s1_valid_in  = s1_hold || req_accept;
   assign wr_valid_in  = commit || wr_valid_ff;
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= req_addr;
         s1_seq_ff  <= req_payload.seq_number;
      end
      if (commit) begin
         wr_addr_ff     <= s1_addr_ff;
         wr_data_ff     <= state_nxt;
         rsp_payload_ff <= check_result;
      end
   end

   // State RAM ports; a held request re-reads its own entry
   assign ram_rd_addr = s1_hold ? s1_addr_ff : req_addr;
   assign ram_wr_en   = clear_ff || commit;
   assign ram_wr_addr = clear_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wr_data = clear_ff ? '0 : state_nxt;

   espar_ram #(
      .WIDTH (StateW),
      .DEPTH (NUM_SA)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Forward the most recent write when it hits the same association
   assign state_cur = (wr_valid_ff && wr_addr_ff == s1_addr_ff) ? wr_data_ff : ram_rd_data;

   espar_check #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_check (
      .seq_number    (s1_seq_ff),
      .last_seq      (state_cur[StateW-1:WINDOW_BITS]),
      .seen_map      (state_cur[WINDOW_BITS-1:0]),
      .start_counter (start_counter_ff),
      .window_size   (window_size_ff),
      .result        (check_result),
      .last_seq_nxt  (last_seq_nxt),
      .seen_map_nxt  (seen_map_nxt)
   );

   assign state_nxt = {last_seq_nxt, seen_map_nxt};

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
